// ----- hw/rtl/lsls_pkg.sv -----
// Package for the link status LED sequencer: register indexes, reset values,
// configuration and state structs. No dependencies.
package lsls_pkg;

  localparam int CNT_W     = 16;
  localparam int PHASE_W   = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Reset values of the registers and of the derived blink thresholds
  localparam logic [CNT_W-1:0]   RST_LINK_TIMEOUT = 16'd2000;
  localparam logic [PHASE_W-1:0] RST_BLINK_PHASE  = 14'd200;
  localparam logic [PHASE_W:0]   RST_BLINK_THR2   = 15'd400;
  localparam logic [CNT_W-1:0]   RST_BLINK_THR3   = 16'd600;
  localparam logic [CNT_W-1:0]   RST_BLINK_THR4   = 16'd800;
  localparam logic [CNT_W-1:0]   RST_SLOW_PERIOD  = 16'd3000;
  localparam logic [CNT_W-1:0]   RST_SLOW_ON      = 16'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINK_TIMEOUT = 2'd0,
    CFG_BLINK_PHASE  = 2'd1,
    CFG_SLOW_PERIOD  = 2'd2,
    CFG_SLOW_ON      = 2'd3
  } cfg_index_t;

  // Blink phase is kept with its multiples precomputed at write time
  typedef struct packed {
    logic [CNT_W-1:0]   link_timeout;
    logic [PHASE_W-1:0] blink_thr1;
    logic [PHASE_W:0]   blink_thr2;
    logic [CNT_W-1:0]   blink_thr3;
    logic [CNT_W-1:0]   blink_thr4;
    logic [CNT_W-1:0]   slow_period;
    logic [CNT_W-1:0]   slow_on;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] ack_age;
    logic             ever_acked;
    logic             prev_link_up;
    logic             connect_blink_done;
    logic [CNT_W-1:0] connect_ticks;
    logic [CNT_W-1:0] slow_ticks;
    logic             led_level;
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

// ----- hw/rtl/link_status_led_sequencer_top.sv -----
// Link status LED sequencer, top level. Uses lsls_pkg and lsls_step.
// Pipeline: input register, then the tick update into the result register.
// Throughput: one tick per cycle while the result sink is not stalling.
// Reset (rst, synchronous, active high): registers to defaults, state cleared,
// both pipeline stages empty. No clearing pass.
module link_status_led_sequencer_top (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [lsls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsls_pkg::CFG_W-1:0]     cfg_data,
  // tick input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           ack_seen,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           led_on,
  output logic                           link_up
);
  import lsls_pkg::*;

  // Configuration registers. The blink phase multiples (x2, x3, x4) are
  // formed at write time so the tick path only compares.
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_timeout <= RST_LINK_TIMEOUT;
      cfg.blink_thr1   <= RST_BLINK_PHASE;
      cfg.blink_thr2   <= RST_BLINK_THR2;
      cfg.blink_thr3   <= RST_BLINK_THR3;
      cfg.blink_thr4   <= RST_BLINK_THR4;
      cfg.slow_period  <= RST_SLOW_PERIOD;
      cfg.slow_on      <= RST_SLOW_ON;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_LINK_TIMEOUT: cfg.link_timeout <= cfg_data;
        CFG_BLINK_PHASE: begin
          cfg.blink_thr1 <= cfg_data[PHASE_W-1:0];
          cfg.blink_thr2 <= {cfg_data[PHASE_W-1:0], 1'b0};
          cfg.blink_thr3 <= CNT_W'({cfg_data[PHASE_W-1:0], 1'b0})
                          + CNT_W'(cfg_data[PHASE_W-1:0]);
          cfg.blink_thr4 <= {cfg_data[PHASE_W-1:0], 2'b00};
        end
        CFG_SLOW_PERIOD:  cfg.slow_period <= cfg_data;
        CFG_SLOW_ON:      cfg.slow_on     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: one tick waiting for the update stage.
  logic s1_valid;
  logic s1_ack;
  logic advance;

  // The update stage moves a tick into the result register whenever that
  // register is empty or being drained this cycle, so the input side only
  // stalls when both stages are full and the sink is stalling.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_ack <= ack_seen;
    end
  end

  // Sequencer state, committed only when a tick transaction completes the
  // update stage.
  state_t st;
  state_t st_next;
  logic   up_next;

  lsls_step u_step (
    .cfg     (cfg),
    .cur     (st),
    .ack     (s1_ack),
    .nxt     (st_next),
    .link_up (up_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_on  <= st_next.led_level;
      link_up <= up_next;
    end
  end

  // An empty result register never holds back the input side
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // A tick that leaves the update stage always lands in the result register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced tick not presented");

  // A reported link up needs an acknowledge at some point
  a_up_needs_ack: assert property (@(posedge clk) disable iff (rst)
    (out_valid && link_up) |-> st.ever_acked)
    else $error("link up without any acknowledge");

  // The connect sequence can only be finished while the link is up
  a_done_only_up: assert property (@(posedge clk) disable iff (rst)
    st.connect_blink_done |-> st.prev_link_up)
    else $error("connect blink done while link down");

endmodule

// ----- hw/rtl/lsls_step.sv -----
// One tick of the sequencer: next state and link status from current state.
// Depends on lsls_pkg.
module lsls_step (
  input  lsls_pkg::cfg_t   cfg,
  input  lsls_pkg::state_t cur,
  input  logic             ack,
  output lsls_pkg::state_t nxt,
  output logic             link_up
);
  import lsls_pkg::*;

  always_comb begin
    logic [CNT_W-1:0] t;
    logic             up;

    nxt = cur;

    // acknowledge age, holds once at or above the timeout
    if (ack) begin
      nxt.ever_acked = 1'b1;
      nxt.ack_age    = '0;
    end else if (cur.ack_age < cfg.link_timeout) begin
      nxt.ack_age = cur.ack_age + CNT_W'(1);
    end
    up = nxt.ever_acked && (nxt.ack_age < cfg.link_timeout);

    nxt.slow_ticks = sat_inc(cur.slow_ticks);
    t = cur.connect_ticks;

    if (up) begin
      if (!cur.prev_link_up) begin
        nxt.connect_blink_done = 1'b0;
        t = '0;
      end
      if (!nxt.connect_blink_done) begin
        if (t < {2'b00, cfg.blink_thr1}) begin
          nxt.led_level = 1'b1;
        end else if (t < {1'b0, cfg.blink_thr2}) begin
          nxt.led_level = 1'b0;
        end else if (t < cfg.blink_thr3) begin
          nxt.led_level = 1'b1;
        end else if (t < cfg.blink_thr4) begin
          nxt.led_level = 1'b0;
        end else begin
          nxt.led_level          = 1'b1;
          nxt.connect_blink_done = 1'b1;
        end
      end else begin
        nxt.led_level = 1'b1;
      end
    end else begin
      // slow blink while down
      if (cur.slow_ticks >= cfg.slow_period) begin
        nxt.slow_ticks = CNT_W'(1);
        nxt.led_level  = 1'b1;
      end else if (cur.slow_ticks >= cfg.slow_on) begin
        nxt.led_level = 1'b0;
      end
      nxt.connect_blink_done = 1'b0;
    end

    nxt.connect_ticks = sat_inc(t);
    nxt.prev_link_up  = up;
    link_up           = up;
  end

endmodule
